>>> rtl/urlpd_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
// No dependencies; imported by every module of the decoder.
package urlpd_pkg;

    // Characters the decoder treats specially
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Most decoded bytes one input byte can cause
    localparam int unsigned MAX_RESULTS = 3;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Work handed from the front to the back: up to three bytes of one input byte
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] count;   // bytes kept after the limit, 0..3
        logic       last;    // input byte closed the stream
        logic       trunc;   // dropped flag after this input byte
    } urlpd_entry_t;

    // 0-9, a-f, A-F
    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) ||
                 (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Nibble value of a hex digit (only meaningful when is_hex holds)
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h61 + 8'd10;
        end
        else begin
            v = c - 8'h41 + 8'd10;
        end
        hex_value = v[3:0];
    endfunction

endpackage

>>> rtl/urlpd_front.sv
// Front end: escape tracking, output limit and drop flag for each accepted byte.
// Depends on urlpd_pkg; produces one queue entry per byte that keeps results or ends the stream.
module urlpd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             in_byte,
    input  logic                   last_in,
    input  logic [15:0]            output_limit,
    output logic                   push,
    output urlpd_pkg::urlpd_entry_t entry
);
    import urlpd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] emitted_reg, emitted_next;
    logic        dropped_reg, dropped_next;

    logic [7:0]  cand [MAX_RESULTS];
    logic [1:0]  ncand;
    logic [1:0]  room;
    logic [1:0]  keep;
    logic [15:0] gap;

    // Candidate bytes and next escape state
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        ncand      = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            cand[i] = 8'h00;
        end

        case (phase_reg)
            PH_PCT:
            begin
                if (is_hex(in_byte))
                begin
                    held_next  = in_byte;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    cand[ncand] = CH_PCT;
                    ncand = ncand + 2'd1;
                end
            end
            PH_DIGIT:
            begin
                phase_next = PH_IDLE;
                if (is_hex(in_byte))
                begin
                    cand[ncand] = {hex_value(held_reg), hex_value(in_byte)};
                    ncand = ncand + 2'd1;
                end
                else
                begin
                    cand[ncand] = CH_PCT;
                    ncand = ncand + 2'd1;
                    cand[ncand] = held_reg;
                    ncand = ncand + 2'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Byte that is not consumed by the escape is handled as fresh
        if (!(phase_reg == PH_PCT && is_hex(in_byte)) &&
            !(phase_reg == PH_DIGIT && is_hex(in_byte)))
        begin
            if (in_byte == CH_PLUS)
            begin
                cand[ncand] = CH_SPACE;
                ncand = ncand + 2'd1;
            end
            else if (in_byte == CH_PCT)
            begin
                phase_next = PH_PCT;
            end
            else
            begin
                cand[ncand] = in_byte;
                ncand = ncand + 2'd1;
            end
        end

        // Stream end flushes a pending escape literally
        if (last_in)
        begin
            if (phase_next == PH_PCT)
            begin
                cand[ncand] = CH_PCT;
                ncand = ncand + 2'd1;
            end
            else if (phase_next == PH_DIGIT)
            begin
                cand[ncand] = CH_PCT;
                ncand = ncand + 2'd1;
                cand[ncand] = held_next;
                ncand = ncand + 2'd1;
            end
        end
    end

    // Room left under the limit, saturated at three
    always_comb
    begin
        gap = output_limit - emitted_reg;
        if (emitted_reg >= output_limit)
        begin
            room = 2'd0;
        end
        else if (gap >= 16'd3)
        begin
            room = 2'd3;
        end
        else
        begin
            room = gap[1:0];
        end
        keep         = (ncand < room) ? ncand : room;
        dropped_next = dropped_reg | (ncand > keep);
        emitted_next = emitted_reg + {14'd0, keep};
    end

    // Queue entry
    always_comb
    begin
        push        = accept && (keep != 2'd0 || last_in);
        entry.byte0 = cand[0];
        entry.byte1 = cand[1];
        entry.byte2 = cand[2];
        entry.count = keep;
        entry.last  = last_in;
        entry.trunc = dropped_next;
    end

    // Stream state, cleared at stream end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            held_reg    <= 8'h00;
            emitted_reg <= 16'd0;
            dropped_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_in)
            begin
                phase_reg   <= PH_IDLE;
                held_reg    <= 8'h00;
                emitted_reg <= 16'd0;
                dropped_reg <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                held_reg    <= held_next;
                emitted_reg <= emitted_next;
                dropped_reg <= dropped_next;
            end
        end
    end

endmodule

>>> rtl/urlpd_queue.sv
// Small register queue of decoded work between the front and the back.
// Depends on urlpd_pkg for the entry type.
module urlpd_queue #(
    parameter int unsigned DEPTH = urlpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  urlpd_pkg::urlpd_entry_t push_entry,
    input  logic                    pop,
    output logic                    full,
    output logic                    head_valid,
    output urlpd_pkg::urlpd_entry_t head_entry
);
    import urlpd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    urlpd_entry_t     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/urlpd_back.sv
// Back end: unpacks queue entries into one result per transfer, output registered.
// Depends on urlpd_pkg for the entry type.
module urlpd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  urlpd_pkg::urlpd_entry_t head_entry,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [7:0]              data_byte,
    output logic                    has_byte,
    output logic                    run_last,
    output logic                    stream_end,
    output logic                    truncated
);
    import urlpd_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       has_reg, run_last_reg, end_reg, trunc_reg;

    logic       load;
    logic       bare;
    logic       final_res;
    logic [7:0] sel_byte;

    // Pick the result at the current index of the head entry
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head_entry.byte0;
            2'd1:    sel_byte = head_entry.byte1;
            2'd2:    sel_byte = head_entry.byte2;
            default: sel_byte = 8'h00;
        endcase
        bare      = (head_entry.count == 2'd0);
        final_res = bare || (idx_reg == head_entry.count - 2'd1);
        load      = head_valid && (!valid_reg || result_ready);
        pop       = load && final_res;
    end

    // Output register and index within the entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (!valid_reg || result_ready)
            begin
                valid_reg <= head_valid;
            end
            if (load)
            begin
                idx_reg <= final_res ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg     <= bare ? 8'h00 : sel_byte;
            has_reg      <= !bare;
            run_last_reg <= final_res;
            end_reg      <= final_res && head_entry.last;
            trunc_reg    <= head_entry.trunc;
        end
    end

    assign result_valid = valid_reg;
    assign data_byte    = data_reg;
    assign has_byte     = has_reg;
    assign run_last     = run_last_reg;
    assign stream_end   = end_reg;
    assign truncated    = trunc_reg;

endmodule

>>> rtl/url_percent_decoder_unit.sv
// Form URL decoder: '+' to space, %XX escapes to bytes, with a per-stream output cap.
// Top level; depends on urlpd_pkg, urlpd_front, urlpd_queue and urlpd_back.
//
// One encoded byte is taken per cycle while the queue has room. Each byte yields
// zero to three decoded results; the back end drives one result per cycle from a
// registered output while result_ready holds and the queue has work, so a byte that
// yields two or three results (an escape broken by a plain byte, or a pending escape
// flushed at stream end) holds the output for one transfer per result, and the input
// stalls only once the QUEUE_DEPTH-entry queue between front and back is full. A
// result passes the queue, then the output register. output_limit (address 0,
// reset 65535) caps decoded bytes per stream; bytes past it are dropped and
// flagged on truncated. A stream end always produces at least one result.
module url_percent_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = urlpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // encoded byte stream
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  in_byte,
    input  logic        last_in,
    // decoded results
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  data_byte,
    output logic        has_byte,
    output logic        run_last,
    output logic        stream_end,
    output logic        truncated,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import urlpd_pkg::*;

    localparam logic REG_OUTPUT_LIMIT = 1'b0;

    logic [15:0]  limit_reg;
    logic         accept;
    logic         push;
    logic         pop;
    logic         full;
    logic         head_valid;
    urlpd_entry_t push_entry;
    urlpd_entry_t head_entry;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUTPUT_LIMIT) ? {16'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 16'hFFFF;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_OUTPUT_LIMIT)
        begin
            limit_reg <= pwdata[15:0];
        end
    end

    // Input transfer when the queue has room
    assign item_ready = !full;
    assign accept     = item_valid && item_ready;

    urlpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .last_in      (last_in),
        .output_limit (limit_reg),
        .push         (push),
        .entry        (push_entry)
    );

    urlpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    urlpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .run_last     (run_last),
        .stream_end   (stream_end),
        .truncated    (truncated)
    );

endmodule
